### hw/rtl/slr_pkg.sv
// ============================================================================
// slr_pkg
// Shared widths, limits and controller/datapath command types for the
// stereo linear resampler.
// ============================================================================
package slr_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int STEP_W            = 19;
    localparam int PHASE_W           = 19;
    localparam int MAX_OUT           = 8;
    localparam int CNT_W             = $clog2(MAX_OUT + 1);
    localparam int FRAC_BITS_DEFAULT = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_first;  // store the very first frame, no output
        logic skip;        // decimate: store frame, drop 1.0 from the phase
        logic start;       // capture current frame and the channel deltas
        logic mul;         // form products, advance the phase by the step
        logic emit;        // load the output register
        logic last;        // this emit ends the run: commit frame and phase
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phase_ge_one;
        logic out_busy;
    } t_status;

endpackage

### hw/rtl/slr_in_if.sv
// ============================================================================
// slr_in_if
// Input channel: one native stereo frame per item.
// ============================================================================
interface slr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

### hw/rtl/slr_out_if.sv
// ============================================================================
// slr_out_if
// Output channel: one interpolated stereo frame per item.
// ============================================================================
interface slr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last_of_run;

    modport source (output valid, output left_out, output right_out,
                    output last_of_run, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input last_of_run, output ready);
endinterface

### hw/rtl/slr_cfg_if.sv
// ============================================================================
// slr_cfg_if
// Configuration write channel carrying the step ratio.
// ============================================================================
interface slr_cfg_if;
    logic        valid;
    logic        ready;
    logic [18:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/slr_ctrl.sv
// ============================================================================
// slr_ctrl
// Sequencer: accepts frames, runs the multiply/emit loop for each output and
// tracks the output count and whether a previous frame is held.
// ============================================================================
module slr_ctrl
    import slr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic             r_have_prev, n_have_prev;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!r_have_prev) begin
                        o_cmd.load_first = 1'b1;
                        n_have_prev      = 1'b1;
                    end else if (i_status.phase_ge_one) begin
                        o_cmd.skip = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    // The run ends when the phase reaches 1.0 or the cap is hit.
                    o_cmd.last = i_status.phase_ge_one || (r_cnt == CNT_W'(MAX_OUT));
                    n_state    = o_cmd.last ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_cnt       <= n_cnt;
        end
    end

endmodule

### hw/rtl/slr_datapath.sv
// ============================================================================
// slr_datapath
// Frame registers, read phase, interpolation multipliers and the output
// register of the stereo linear resampler.
// ============================================================================
module slr_datapath
    import slr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic signed [SAMPLE_W-1:0] i_left,
    input  logic signed [SAMPLE_W-1:0] i_right,
    input  logic                       i_cfg_valid,
    input  logic [STEP_W-1:0]          i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_left,
    output logic signed [SAMPLE_W-1:0] o_right,
    output logic                       o_last
);

    // Running phase must hold a value below 1.0 plus the largest step.
    localparam int MAXW = (STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS;
    localparam int PW   = MAXW + 1;
    localparam int DW   = SAMPLE_W + 1;
    localparam int PRW  = DW + FRAC_BITS + 1;
    localparam int SW   = SAMPLE_W + 2;

    localparam logic [PW-1:0]     One       = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [STEP_W-1:0] StepReset = STEP_W'(64'd1 << FRAC_BITS);

    logic [STEP_W-1:0]          r_step;
    logic [PW-1:0]              r_phase;
    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r, r_cur_l, r_cur_r;
    logic signed [DW-1:0]       r_diff_l, r_diff_r;
    logic signed [PRW-1:0]      r_prod_l, r_prod_r;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;
    logic                       r_out_last;

    logic                       w_ge_one;
    logic [PW-1:0]              w_sub, w_fin;
    logic signed [FRAC_BITS:0]  w_frac;
    logic signed [PRW-1:0]      w_prod_l, w_prod_r, w_t_l, w_t_r;
    logic signed [SW-1:0]       w_sum_l, w_sum_r;

    assign w_ge_one = (r_phase >= One);
    assign w_sub    = r_phase - One;
    // Below 1.0 (only when the output cap stops the run) the phase restarts at zero.
    assign w_fin    = w_ge_one ? PW'(w_sub[PHASE_W-1:0]) : '0;

    assign w_frac   = $signed({1'b0, r_phase[FRAC_BITS-1:0]});
    assign w_prod_l = r_diff_l * w_frac;
    assign w_prod_r = r_diff_r * w_frac;

    // The arithmetic shift floors, so the result always lies between prev and cur.
    assign w_t_l   = r_prod_l >>> FRAC_BITS;
    assign w_t_r   = r_prod_r >>> FRAC_BITS;
    assign w_sum_l = SW'(r_prev_l) + w_t_l[SW-1:0];
    assign w_sum_r = SW'(r_prev_r) + w_t_r[SW-1:0];

    assign o_status.phase_ge_one = w_ge_one;
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= StepReset;
            r_phase     <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (i_cmd.load_first) begin
                r_prev_l <= i_left;
                r_prev_r <= i_right;
            end
            if (i_cmd.skip) begin
                r_prev_l <= i_left;
                r_prev_r <= i_right;
                r_phase  <= w_fin;
            end
            if (i_cmd.mul) begin
                r_phase <= r_phase + PW'(r_step);
            end
            if (i_cmd.emit && i_cmd.last) begin
                r_prev_l <= r_cur_l;
                r_prev_r <= r_cur_r;
                r_phase  <= w_fin;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur_l  <= i_left;
            r_cur_r  <= i_right;
            r_diff_l <= DW'(i_left) - DW'(r_prev_l);
            r_diff_r <= DW'(i_right) - DW'(r_prev_r);
        end
        if (i_cmd.mul) begin
            r_prod_l <= w_prod_l;
            r_prod_r <= w_prod_r;
        end
        if (i_cmd.emit) begin
            r_out_l    <= w_sum_l[SAMPLE_W-1:0];
            r_out_r    <= w_sum_r[SAMPLE_W-1:0];
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_l;
    assign o_right     = r_out_r;
    assign o_last      = r_out_last;

endmodule

### hw/rtl/stereo_linear_resampler_core.sv
// ============================================================================
// stereo_linear_resampler_core
// Stereo linear-interpolation sample rate converter.
//
// i_in takes one native stereo frame per item; o_out delivers interpolated
// frames, with last_of_run marking the final one caused by an input frame.
// i_cfg writes the Q(FRAC_BITS) step ratio (native rate / output rate); it is
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. Each output an input frame causes passes
// the shared multiply/emit loop (a multiply step, then an emit step), so a
// frame with N outputs (N up to 8) occupies the block for its accept plus N
// such passes. Frames that cause no output never enter the loop.
// The next frame is accepted once the last output of the previous one has
// entered the output register, even if that output is not yet taken.
// A stalled receiver holds the loop at its emit step; nothing is lost.
// Reset clears the held frame and phase and sets the step to 1.0; the first
// frame after reset is only stored and produces no output.
// ============================================================================
module stereo_linear_resampler_core
    import slr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    slr_in_if.sink  i_in,
    slr_out_if.source o_out,
    slr_cfg_if.sink i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    slr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    slr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_left      (i_in.left_in),
        .i_right     (i_in.right_in),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_left      (o_out.left_out),
        .o_right     (o_out.right_out),
        .o_last      (o_out.last_of_run)
    );

endmodule
